[src/euler_angles_to_axis_vectors_core_assert.svh]
// assertion macros for the euler angle core
`ifndef EULER_ANGLES_TO_AXIS_VECTORS_CORE_ASSERT_SVH
`define EULER_ANGLES_TO_AXIS_VECTORS_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication outside reset
`define EA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/eav_pkg.sv]
package eav_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int OUT_W             = 16;
    localparam int Q30_W             = 32;
    localparam logic signed [31:0] COEF1  = 32'sd1686629713;
    localparam logic signed [31:0] COEF3  = 32'sd693598668;
    localparam logic signed [31:0] COEF5  = 32'sd85569306;
    localparam logic signed [31:0] COEF7  = 32'sd5026995;
    localparam logic signed [31:0] COEF9  = 32'sd172272;
    localparam logic signed [31:0] COEF11 = 32'sd3864;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    // q30 product rounded half away from zero
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        neg = a[31] ^ b[31];
        ua  = a[31] ? (32'd0 - a) : a;
        ub  = b[31] ? (32'd0 - b) : b;
        p   = ((64'(ua) * 64'(ub)) + 64'd536870912) >> 30;
        return neg ? -(32'(p)) : 32'(p);
    endfunction
endpackage

[src/eav_if.sv]
interface eav_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic [15:0] roll_angle;
    modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface eav_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    modport source (output valid, forward_x, forward_y, forward_z, side_x, side_y,
                    side_z, up_x, up_y, up_z, input ready);
    modport sink   (input valid, forward_x, forward_y, forward_z, side_x, side_y,
                    side_z, up_x, up_y, up_z, output ready);
endinterface

interface eav_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/euler_angles_to_axis_vectors_core.sv]
// euler angle to axis vector core
// in channel: one word of pitch, yaw, roll binary angles (full turn = 2^ANGLE_BITS)
// out channel: forward, side and up vectors, signed, 1.0 = 2^FRACTION_BITS
// cfg channel: axis_mode bit, 0 gives right vector as side, 1 gives left
//   write it only while no word is in flight; it accepts whenever out of reset
// pipeline: an accepted input word passes 10 sine stages and 2 product stages
//   before it is presented as an output word
// throughput: one word per cycle unless the receiver stalls; the whole pipeline advances together
// when the receiver stalls the pipeline freezes and holds every word,
//   and in.ready drops while the output word is waiting
// reset clears all valid bits and axis_mode; payload stages are not reset
//   both ready outputs stay low while reset is held
module euler_angles_to_axis_vectors_core #(
    parameter int ANGLE_BITS    = eav_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eav_pkg::FRACTION_BITS_DEF
) (
    input logic    i_clk,
    input logic    i_rst_n,
    eav_in_if.sink   in_ch,
    eav_cfg_if.sink  cfg_ch,
    eav_out_if.source out_ch
);
    localparam int SW  = FRACTION_BITS + 2;
    localparam int LAT = 12;

    logic             r_mode;
    logic [LAT-1:0]   r_vld;
    logic             n_en;
    logic signed [SW-1:0] n_s[6];
    logic [8:0][15:0] n_vec;

    // pipeline advances when the output is free or being taken
    assign n_en         = !r_vld[LAT-1] || out_ch.ready;
    assign in_ch.ready  = n_en && i_rst_n;
    assign cfg_ch.ready = i_rst_n;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (cfg_ch.valid) begin
            r_mode <= cfg_ch.data;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LAT-2:0], in_ch.valid};
        end
    end

    // six sine units, cosine is sine of angle plus a quarter
    for (genvar g = 0; g < 6; g++) begin : g_sine
        logic [ANGLE_BITS-1:0] w_a;
        always_comb begin
            case (g / 2)
                0: w_a = ANGLE_BITS'(in_ch.pitch_angle);
                1: w_a = ANGLE_BITS'(in_ch.yaw_angle);
                default: w_a = ANGLE_BITS'(in_ch.roll_angle);
            endcase
        end
        eav_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_sine (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_angle(w_a + ((g % 2 == 1) ? (ANGLE_BITS'(1) << (ANGLE_BITS - 2))
                                           : ANGLE_BITS'(0))),
            .o_sine (n_s[g])
        );
    end

    eav_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_mode(r_mode),
        .i_sp  (n_s[0]), .i_cp(n_s[1]),
        .i_sy  (n_s[2]), .i_cy(n_s[3]),
        .i_sr  (n_s[4]), .i_cr(n_s[5]),
        .o_vec (n_vec)
    );

    assign out_ch.valid     = r_vld[LAT-1];
    assign out_ch.forward_x = n_vec[0];
    assign out_ch.forward_y = n_vec[1];
    assign out_ch.forward_z = n_vec[2];
    assign out_ch.side_x    = n_vec[3];
    assign out_ch.side_y    = n_vec[4];
    assign out_ch.side_z    = n_vec[5];
    assign out_ch.up_x      = n_vec[6];
    assign out_ch.up_y      = n_vec[7];
    assign out_ch.up_z      = n_vec[8];

`include "euler_angles_to_axis_vectors_core_assert.svh"
    `EA_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !r_vld[LAT-1], in_ch.ready,
        "input refused while output stage is empty")
    `EA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(r_vld), "stall changed pipeline occupancy")
    `EA_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, in_ch.valid && in_ch.ready,
        r_vld[0], "accepted word not tracked in pipeline")
endmodule

[src/eav_sine.sv]
// pipelined quarter-wave sine: horner steps in successive stages, one word a cycle while i_en is high
module eav_sine #(
    parameter int ANGLE_BITS    = eav_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eav_pkg::FRACTION_BITS_DEF,
    localparam int DEPTH        = 9
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ANGLE_BITS-1:0]         i_angle,
    output logic signed [FRACTION_BITS+1:0] o_sine
);
    localparam int QB = ANGLE_BITS - 2;
    localparam int SW = FRACTION_BITS + 2;

    logic signed [31:0] r_t   [DEPTH];
    logic signed [31:0] r_t2  [DEPTH];
    logic signed [31:0] r_p   [DEPTH];
    logic               r_full[DEPTH];
    logic               r_neg [DEPTH];
    logic signed [SW-1:0] r_out;

    logic [ANGLE_BITS-1:0] n_r;
    logic                  n_full;
    logic [QB:0]           n_red;
    logic signed [31:0]    n_s;
    logic signed [32:0]    n_rnd;
    logic signed [SW-1:0]  n_out;

    // quadrant fold
    always_comb begin
        n_r   = i_angle & ((ANGLE_BITS)'(1) << QB) - 1'b1;
        n_red = i_angle[QB] ? ((QB+1)'(1) << QB) - (QB+1)'(n_r) : (QB+1)'(n_r);
        n_full = n_red[QB];
    end

    // stage 0: t, stage 1: t squared, then horner steps, then t times p
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0]    <= 32'(n_red[QB-1:0]) <<< (30 - QB);
            r_full[0] <= n_full;
            r_neg[0]  <= i_angle[ANGLE_BITS-1];
            r_t2[0]   <= '0;
            r_p[0]    <= -eav_pkg::COEF11;
            for (int k = 1; k < DEPTH; k++) begin
                r_t[k]    <= r_t[k-1];
                r_full[k] <= r_full[k-1];
                r_neg[k]  <= r_neg[k-1];
            end
            for (int k = 2; k < DEPTH; k++) begin
                r_t2[k]   <= r_t2[k-1];
            end
            r_t2[1] <= eav_pkg::mul_q30(r_t[0], r_t[0]);
            r_p[1]  <= r_p[0];
            r_p[2]  <= eav_pkg::COEF9 + eav_pkg::mul_q30(r_t2[1], r_p[1]);
            r_p[3]  <= -eav_pkg::COEF7 + eav_pkg::mul_q30(r_t2[2], r_p[2]);
            r_p[4]  <= eav_pkg::COEF5 + eav_pkg::mul_q30(r_t2[3], r_p[3]);
            r_p[5]  <= -eav_pkg::COEF3 + eav_pkg::mul_q30(r_t2[4], r_p[4]);
            r_p[6]  <= eav_pkg::COEF1 + eav_pkg::mul_q30(r_t2[5], r_p[5]);
            r_p[7]  <= eav_pkg::mul_q30(r_t[6], r_p[6]);
            r_p[8]  <= r_p[7];
            r_out   <= n_out;
        end
    end

    // clamp, round to output fraction, apply sign
    always_comb begin
        n_s = r_p[8];
        if (n_s < 0) n_s = '0;
        if (n_s > eav_pkg::Q30_ONE) n_s = eav_pkg::Q30_ONE;
        if (FRACTION_BITS < 30)
            n_rnd = (33'(n_s) + (33'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
        else
            n_rnd = 33'(n_s) <<< (FRACTION_BITS - 30);
        if (r_full[8]) n_rnd = 33'sd1 <<< FRACTION_BITS;
        n_out = r_neg[8] ? -SW'(n_rnd) : SW'(n_rnd);
    end

    assign o_sine = r_out;
endmodule

[src/eav_combine.sv]
// two-stage product and sum network producing the nine axis components
module eav_combine #(
    parameter int FRACTION_BITS = eav_pkg::FRACTION_BITS_DEF,
    localparam int SW = FRACTION_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_mode,
    input  logic signed [SW-1:0] i_sp, i_cp, i_sy, i_cy, i_sr, i_cr,
    output logic [8:0][15:0]     o_vec
);
    logic signed [SW-1:0] r_srsp, r_crsp, r_cpcy, r_cpsy, r_sp, r_crsy, r_crcy;
    logic signed [SW-1:0] r_srcp, r_crcp, r_srsy, r_srcy, r_sy, r_cy;
    logic [8:0][15:0]     r_vec;
    logic                 r_mode;

    // fixed-point product rounded half away from zero
    function automatic logic signed [SW+1:0] fmul(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        logic          neg;
        logic [SW-1:0] ua;
        logic [SW-1:0] ub;
        logic [2*SW-1:0] p;
        neg = a[SW-1] ^ b[SW-1];
        ua  = a[SW-1] ? SW'(-a) : a;
        ub  = b[SW-1] ? SW'(-b) : b;
        p   = ((2*SW)'(ua) * (2*SW)'(ub) + ((2*SW)'(1) << (FRACTION_BITS - 1)))
              >> FRACTION_BITS;
        return neg ? -(SW+2)'(p) : (SW+2)'(p);
    endfunction

    function automatic logic [15:0] clamp(input logic signed [SW+1:0] v);
        logic signed [SW+1:0] one;
        logic signed [SW+1:0] c;
        one = (SW+2)'(1) <<< FRACTION_BITS;
        c = v > one ? one : (v < -one ? -one : v);
        return 16'(c);
    endfunction

    // stage a: pairwise products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_srsp <= SW'(fmul(i_sr, i_sp));
            r_crsp <= SW'(fmul(i_cr, i_sp));
            r_cpcy <= SW'(fmul(i_cp, i_cy));
            r_cpsy <= SW'(fmul(i_cp, i_sy));
            r_crsy <= SW'(fmul(i_cr, i_sy));
            r_crcy <= SW'(fmul(i_cr, i_cy));
            r_srcp <= SW'(fmul(i_sr, i_cp));
            r_crcp <= SW'(fmul(i_cr, i_cp));
            r_srsy <= SW'(fmul(i_sr, i_sy));
            r_srcy <= SW'(fmul(i_sr, i_cy));
            r_sp   <= i_sp;
            r_sy   <= i_sy;
            r_cy   <= i_cy;
            r_mode <= i_mode;
        end
    end

    // stage b: triple products, sums, clamp and side sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec[0] <= clamp((SW+2)'(r_cpcy));
            r_vec[1] <= clamp((SW+2)'(r_cpsy));
            r_vec[2] <= 16'(-r_sp);
            r_vec[3] <= clamp(r_mode ? fmul(r_srsp, r_cy) - (SW+2)'(r_crsy)
                                     : (SW+2)'(r_crsy) - fmul(r_srsp, r_cy));
            r_vec[4] <= clamp(r_mode ? fmul(r_srsp, r_sy) + (SW+2)'(r_crcy)
                                     : -fmul(r_srsp, r_sy) - (SW+2)'(r_crcy));
            r_vec[5] <= clamp(r_mode ? (SW+2)'(r_srcp) : -(SW+2)'(r_srcp));
            r_vec[6] <= clamp(fmul(r_crsp, r_cy) + (SW+2)'(r_srsy));
            r_vec[7] <= clamp(fmul(r_crsp, r_sy) - (SW+2)'(r_srcy));
            r_vec[8] <= clamp((SW+2)'(r_crcp));
        end
    end

    assign o_vec = r_vec;
endmodule

[verif/euler_angles_to_axis_vectors_core_tb.sv]
module euler_angles_to_axis_vectors_core_tb;
    localparam int PIPE_CYCLES = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_WORDS = 800;
    localparam logic [15:0] QUARTER = 16'h4000;
    localparam logic signed [15:0] ONE_FX = 16'sd16384;
    localparam logic MODE_RIGHT = 1'b0;
    localparam logic MODE_LEFT  = 1'b1;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] fx, fy, fz, sx, sy, sz, ux, uy, uz;
    } t_axes;

    // one row of the directed part; known is set where the result is typed in
    typedef struct packed {
        t_angles ang;
        logic    known;
        t_axes   res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    eav_in_if  in_ch();
    eav_out_if out_ch();
    eav_cfg_if cfg_ch();

    euler_angles_to_axis_vectors_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .cfg_ch  (cfg_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    logic  axis_mode_q = MODE_RIGHT;
    t_axes axes_pending[$];
    int    mismatch_cnt = 0;
    int    idle_cycles = 0;
    bit    hold_off = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_len = 0;
    bit    timed_out = 1'b0;

    // rounded product, half away from zero
    function automatic longint rmul(longint a, longint b, int sh);
        bit     neg;
        longint ua, ub, p;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = ua * ub;
        if (sh > 0) p = (p + (longint'(1) << (sh - 1))) >>> sh;
        return neg ? -p : p;
    endfunction

    function automatic longint sat_one(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // polynomial sine over the first quarter turn
    function automatic longint quarter_sin(longint r);
        longint t, t2, p, s;
        if (r >= 16384) return 16384;
        t = r <<< 16;
        t2 = rmul(t, t, 30);
        p = -3864;
        p = 172272 + rmul(t2, p, 30);
        p = -5026995 + rmul(t2, p, 30);
        p = 85569306 + rmul(t2, p, 30);
        p = -693598668 + rmul(t2, p, 30);
        p = 1686629713 + rmul(t2, p, 30);
        s = rmul(t, p, 30);
        if (s < 0) s = 0;
        if (s > (longint'(1) << 30)) s = longint'(1) << 30;
        s = (s + (longint'(1) << 15)) >>> 16;
        return sat_one(s);
    endfunction

    function automatic longint bam_sin(logic [15:0] a);
        logic [1:0] q;
        longint     r, s;
        q = a[15:14];
        r = a[13:0];
        s = q[0] ? quarter_sin(16384 - r) : quarter_sin(r);
        return q[1] ? -s : s;
    endfunction

    function automatic t_axes rotate_axes(t_angles a, logic mode);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp, rx, ry, rz;
        t_axes  o;
        sp = bam_sin(a.pitch); cp = bam_sin(a.pitch + QUARTER);
        sy = bam_sin(a.yaw);   cy = bam_sin(a.yaw + QUARTER);
        sr = bam_sin(a.roll);  cr = bam_sin(a.roll + QUARTER);
        srsp = rmul(sr, sp, 14);
        crsp = rmul(cr, sp, 14);
        rx = sat_one(-rmul(srsp, cy, 14) + rmul(cr, sy, 14));
        ry = sat_one(-rmul(srsp, sy, 14) - rmul(cr, cy, 14));
        rz = sat_one(-rmul(sr, cp, 14));
        if (mode == MODE_LEFT) begin
            rx = -rx; ry = -ry; rz = -rz;
        end
        o.fx = 16'(sat_one(rmul(cp, cy, 14)));
        o.fy = 16'(sat_one(rmul(cp, sy, 14)));
        o.fz = 16'(-sp);
        o.sx = 16'(rx); o.sy = 16'(ry); o.sz = 16'(rz);
        o.ux = 16'(sat_one(rmul(crsp, cy, 14) + rmul(sr, sy, 14)));
        o.uy = 16'(sat_one(rmul(crsp, sy, 14) - rmul(sr, cy, 14)));
        o.uz = 16'(sat_one(rmul(cr, cp, 14)));
        return o;
    endfunction

    // receiver: own stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_len > 0) begin
            out_ch.ready <= 1'b0;
            hold_len <= hold_len - 1;
        end else if (hold_off && !hold_done) begin
            hold_len <= 150;
            hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // output word check against the oldest expectation
    always @(posedge i_clk) begin
        t_axes got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.forward_x, out_ch.forward_y, out_ch.forward_z,
                    out_ch.side_x, out_ch.side_y, out_ch.side_z,
                    out_ch.up_x, out_ch.up_y, out_ch.up_z};
            if (axes_pending.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected word %h", got);
            end else begin
                want = axes_pending.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("word mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_mode(logic mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        axis_mode_q = mode;
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one word, hold it until taken; expectation recorded on acceptance
    task automatic send_angles(t_angles a, logic known, t_axes res);
        in_ch.valid <= 1'b1;
        in_ch.pitch_angle <= a.pitch;
        in_ch.yaw_angle <= a.yaw;
        in_ch.roll_angle <= a.roll;
        do @(posedge i_clk); while (!in_ch.ready);
        axes_pending.push_back(known ? res : rotate_axes(a, axis_mode_q));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (axes_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 4) @(posedge i_clk);
    endtask

    function automatic t_angles random_angles();
        t_angles a;
        case ($urandom_range(0, 4))
            0: a = '{16'($urandom_range(0, 3)) << 14, 16'($urandom_range(0, 3)) << 14,
                     16'($urandom_range(0, 3)) << 14};
            1: a = '{16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 2)) - 16'd1,
                     16'($urandom), 16'($urandom)};
            default: a = '{16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        return a;
    endfunction

    t_row  rows[$];
    t_axes none;

    initial begin
        int gap, burst;
        // inputs start at known values
        in_ch.valid = 1'b0;
        in_ch.pitch_angle = '0;
        in_ch.yaw_angle = '0;
        in_ch.roll_angle = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 1'b0;
        none = '0;
        // zero angles: identity frame, right vector points along minus y
        rows.push_back('{'{16'h0, 16'h0, 16'h0}, 1'b1,
                         '{ONE_FX, 16'sd0, 16'sd0, 16'sd0, -ONE_FX, 16'sd0,
                           16'sd0, 16'sd0, ONE_FX}});
        rows.push_back('{'{16'h4000, 16'h0, 16'h0}, 1'b1,
                         '{16'sd0, 16'sd0, -ONE_FX, 16'sd0, -ONE_FX, 16'sd0,
                           ONE_FX, 16'sd0, 16'sd0}});
        rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, none});
        rows.push_back('{'{16'hC000, 16'h4000, 16'h4000}, 1'b0, none});
        rows.push_back('{'{16'h3FFF, 16'h4001, 16'hBFFF}, 1'b0, none});
        rows.push_back('{'{16'h0001, 16'h7FFF, 16'h8001}, 1'b0, none});
        rows.push_back('{'{16'h5555, 16'hAAAA, 16'h2000}, 1'b0, none});
        rows.push_back('{'{16'h2000, 16'hE000, 16'h6000}, 1'b0, none});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under both side-vector forms
        foreach (rows[k]) send_angles(rows[k].ang, rows[k].known, rows[k].res);
        drain();
        write_mode(MODE_LEFT);
        foreach (rows[k]) send_angles(rows[k].ang, 1'b0, none);
        drain();
        write_mode(MODE_RIGHT);

        // random bursts with gaps, mode sometimes rewritten at random between phases
        for (int n = 0; n < RANDOM_WORDS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                send_angles(random_angles(), 1'b0, none);
                n++;
            end
            if (n > 200 && n < 260) hold_off = 1'b1;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_mode(logic'($urandom_range(0, 1)));
            end
        end
        drain();

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
